>>> design/sfs_pkg.sv
package sfs_pkg;

   // configuration port geometry
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_HARMONIC_COUNT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_AMPLITUDE      = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FREQUENCY      = 2'd2;

   // register reset values
   localparam logic [6:0]         HARMONIC_COUNT_RST = 7'd16;
   localparam logic signed [15:0] AMPLITUDE_RST      = 16'sd256;
   localparam logic [15:0]        FREQUENCY_RST      = 16'd256;

   // fixed-point constants
   localparam int PHASE_W     = 16;
   localparam int WAVE_W      = 19;
   localparam int ANGLE_W     = 24;
   localparam int SPLIT_W     = 24;
   localparam int MUL_A_W     = 25;
   localparam int MUL_B_W     = 31;
   localparam int PP_W        = MUL_A_W + MUL_B_W;
   localparam int SINE_W      = 16;
   localparam int RECIP_W     = 17;
   localparam int HPROD_W     = 35;
   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
   localparam logic [29:0]     INV_PI_Q30  = 30'd341782638;
   localparam int OUT_MAX = 262143;
   localparam int OUT_MIN = -262144;

   // configuration registers as seen by the datapath
   typedef struct packed {
      logic [6:0]         harmonic_count;
      logic signed [15:0] amplitude;
      logic [15:0]        frequency;
   } cfg_type;

   // controller states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INIT,
      ST_LOOP,
      ST_DRAIN,
      ST_S_LO,
      ST_S_HI,
      ST_S_ADD,
      ST_ROUND,
      ST_V_LO,
      ST_V_HI,
      ST_V_ADD,
      ST_OUT
   } state_type;

   // datapath operations
   typedef enum logic [3:0] {
      OP_NOP,
      OP_FP,
      OP_INIT,
      OP_STEP,
      OP_S_LO,
      OP_S_HI,
      OP_S_ADD,
      OP_ROUND,
      OP_V_LO,
      OP_V_HI,
      OP_V_ADD,
      OP_OUT
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } cmd_type;

   typedef struct packed {
      logic no_harm;
      logic last_harm;
      logic pipe_busy;
   } status_type;

endpackage

>>> design/sawtooth_fourier_series_synth_top.sv
// Band-limited sawtooth synthesizer: one phase sample in, one wave value out.
//
// Input: a beat is taken at a rising edge with start high and busy low;
// req_phase is unsigned Q0.16 turns and is sampled at that edge only.
// Output: rsp_wave_value (signed Q11.8, saturated) is valid for exactly one
// cycle while rsp_strobe is high; the receiver cannot stall and must take it.
// Configuration: csr_valid/csr_ready write channel, csr_index selects
// harmonic_count (0), amplitude (1) or frequency (2); other indexes are
// dropped. csr_ready is always high. Write only while busy is low.
//
// Sequence, with N the harmonic count clamped to MAX_HARMONICS: after the
// accepting edge busy stays high through a setup state, the harmonic loop
// with one harmonic per cycle through the shared sine table and
// multiply-accumulate (skipped when N is 0), a drain of the table/multiply
// pipeline and the split multiplies for the 1/pi and amplitude scale. The
// strobe is high in the first cycle with busy low, and a new beat may be
// accepted in that same cycle.
// Reset returns the controller to idle and the registers to 16, 1.0, 1.0.
module sawtooth_fourier_series_synth_top #(
   parameter int MAX_HARMONICS  = 64,
   parameter int SINE_ADDR_BITS = 10
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [sfs_pkg::PHASE_W-1:0]         req_phase,
   output logic                                rsp_strobe,
   output logic signed [sfs_pkg::WAVE_W-1:0]   rsp_wave_value,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [sfs_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [sfs_pkg::CSR_DATA_W-1:0]      csr_data
);

   sfs_pkg::cfg_type    cfg;
   sfs_pkg::cmd_type    cmd;
   sfs_pkg::status_type status;

   // configuration registers
   sfs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // sequencer
   sfs_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   // arithmetic
   sfs_dpath #(
      .MAX_HARMONICS  (MAX_HARMONICS),
      .SINE_ADDR_BITS (SINE_ADDR_BITS)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .cfg            (cfg),
      .req_phase      (req_phase),
      .rsp_strobe     (rsp_strobe),
      .rsp_wave_value (rsp_wave_value)
   );

   // an accepted beat always makes the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted beat did not raise busy");

   // results are single-cycle strobes
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held for more than one cycle");

   // a result only follows work in progress
   a_strobe_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("result strobe without a preceding busy cycle");

   // no harmonic pipeline activity while idle
   a_pipe_idle: assert property (@(posedge clock) disable iff (reset)
      (!busy && !rsp_strobe) |-> !status.pipe_busy)
      else $error("harmonic pipeline active while idle");

endmodule

>>> design/sfs_csr.sv
module sfs_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [sfs_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [sfs_pkg::CSR_DATA_W-1:0]       csr_data,
   output sfs_pkg::cfg_type                     cfg
);

   logic [6:0]         harmonic_count_ff;
   logic signed [15:0] amplitude_ff;
   logic [15:0]        frequency_ff;

   // writes are always taken
   assign csr_ready = 1'b1;

   // register file, unknown indexes dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         harmonic_count_ff <= sfs_pkg::HARMONIC_COUNT_RST;
         amplitude_ff      <= sfs_pkg::AMPLITUDE_RST;
         frequency_ff      <= sfs_pkg::FREQUENCY_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            sfs_pkg::CSR_HARMONIC_COUNT: harmonic_count_ff <= csr_data[6:0];
            sfs_pkg::CSR_AMPLITUDE:      amplitude_ff      <= $signed(csr_data[15:0]);
            sfs_pkg::CSR_FREQUENCY:      frequency_ff      <= csr_data[15:0];
            default: begin
            end
         endcase
      end
   end

   assign cfg.harmonic_count = harmonic_count_ff;
   assign cfg.amplitude      = amplitude_ff;
   assign cfg.frequency      = frequency_ff;

endmodule

>>> design/sfs_ctrl.sv
module sfs_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  sfs_pkg::status_type status,
   output sfs_pkg::cmd_type    cmd
);

   sfs_pkg::state_type state_ff;
   sfs_pkg::state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sfs_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and datapath command
   always_comb begin
      state_in = state_ff;
      cmd.op   = sfs_pkg::OP_NOP;
      case (state_ff)
         sfs_pkg::ST_IDLE: begin
            if (start) begin
               cmd.op   = sfs_pkg::OP_FP;
               state_in = sfs_pkg::ST_INIT;
            end
         end
         sfs_pkg::ST_INIT: begin
            cmd.op   = sfs_pkg::OP_INIT;
            state_in = status.no_harm ? sfs_pkg::ST_DRAIN : sfs_pkg::ST_LOOP;
         end
         sfs_pkg::ST_LOOP: begin
            cmd.op = sfs_pkg::OP_STEP;
            if (status.last_harm) begin
               state_in = sfs_pkg::ST_DRAIN;
            end
         end
         sfs_pkg::ST_DRAIN: begin
            if (!status.pipe_busy) begin
               state_in = sfs_pkg::ST_S_LO;
            end
         end
         sfs_pkg::ST_S_LO: begin
            cmd.op   = sfs_pkg::OP_S_LO;
            state_in = sfs_pkg::ST_S_HI;
         end
         sfs_pkg::ST_S_HI: begin
            cmd.op   = sfs_pkg::OP_S_HI;
            state_in = sfs_pkg::ST_S_ADD;
         end
         sfs_pkg::ST_S_ADD: begin
            cmd.op   = sfs_pkg::OP_S_ADD;
            state_in = sfs_pkg::ST_ROUND;
         end
         sfs_pkg::ST_ROUND: begin
            cmd.op   = sfs_pkg::OP_ROUND;
            state_in = sfs_pkg::ST_V_LO;
         end
         sfs_pkg::ST_V_LO: begin
            cmd.op   = sfs_pkg::OP_V_LO;
            state_in = sfs_pkg::ST_V_HI;
         end
         sfs_pkg::ST_V_HI: begin
            cmd.op   = sfs_pkg::OP_V_HI;
            state_in = sfs_pkg::ST_V_ADD;
         end
         sfs_pkg::ST_V_ADD: begin
            cmd.op   = sfs_pkg::OP_V_ADD;
            state_in = sfs_pkg::ST_OUT;
         end
         sfs_pkg::ST_OUT: begin
            cmd.op   = sfs_pkg::OP_OUT;
            state_in = sfs_pkg::ST_IDLE;
         end
         default: begin
            state_in = sfs_pkg::ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != sfs_pkg::ST_IDLE);

endmodule

>>> design/sfs_dpath.sv
module sfs_dpath #(
   parameter int MAX_HARMONICS  = 64,
   parameter int SINE_ADDR_BITS = 10
) (
   input  logic                                clock,
   input  logic                                reset,
   input  sfs_pkg::cmd_type                    cmd,
   output sfs_pkg::status_type                 status,
   input  sfs_pkg::cfg_type                    cfg,
   input  logic [sfs_pkg::PHASE_W-1:0]         req_phase,
   output logic                                rsp_strobe,
   output logic signed [sfs_pkg::WAVE_W-1:0]   rsp_wave_value
);

   localparam int QSIZE  = 1 << SINE_ADDR_BITS;
   localparam int QA_W   = SINE_ADDR_BITS + 1;
   localparam int IDX_W  = $clog2(MAX_HARMONICS + 1);
   localparam int SUM_W  = 34 + IDX_W;
   localparam int V_W    = SUM_W + 1;
   localparam int WIDE_W = SUM_W + 31;
   localparam int Y_W    = WIDE_W - 31;
   localparam int PP_W   = sfs_pkg::PP_W;
   localparam int SP_LO  = sfs_pkg::SPLIT_W;

   typedef logic [sfs_pkg::SINE_W-1:0]  qtab_type [QSIZE+1];
   typedef logic [sfs_pkg::RECIP_W-1:0] rtab_type [MAX_HARMONICS+1];

   // shift-subtract quotient for the table builders
   function automatic longint unsigned const_udiv(longint unsigned num,
                                                  longint unsigned den);
      longint unsigned quo;
      longint unsigned rmd;
      int              b;
      quo = '0;
      rmd = '0;
      for (b = 63; b >= 0; b--) begin
         rmd = {rmd[62:0], num[b]};
         if (rmd >= den) begin
            rmd    = rmd - den;
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   // quarter-wave sine in Q1.15 from a Q2.30 series through x^15
   function automatic qtab_type build_qtab();
      qtab_type          tab;
      longint unsigned   x;
      longint unsigned   term;
      longint            acc;
      longint            r;
      int                k;
      int                n;
      for (k = 0; k <= QSIZE; k++) begin
         x    = (sfs_pkg::HALF_PI_Q30 * 64'(k)) >> SINE_ADDR_BITS;
         term = x;
         acc  = longint'(x);
         for (n = 1; n <= 7; n++) begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = const_udiv(term, 64'((2 * n) * (2 * n + 1)));
            if ((n & 1) == 1) acc = acc - longint'(term);
            else acc = acc + longint'(term);
         end
         if (acc < 0) acc = 0;
         r = (acc + 64'sd16384) >>> 15;
         if (r > 32768) r = 32768;
         tab[k] = sfs_pkg::SINE_W'(r);
      end
      return tab;
   endfunction

   // 1/i in Q1.16, rounded
   function automatic rtab_type build_rtab();
      rtab_type tab;
      int       k;
      tab[0] = '0;
      for (k = 1; k <= MAX_HARMONICS; k++) begin
         tab[k] = sfs_pkg::RECIP_W'(const_udiv(64'(65536 + (k >> 1)), 64'(k)));
      end
      return tab;
   endfunction

   localparam qtab_type QTAB = build_qtab();
   localparam rtab_type RTAB = build_rtab();

   // loop registers
   logic [sfs_pkg::ANGLE_W-1:0]        fp_ff;
   logic [sfs_pkg::ANGLE_W-1:0]        angle_ff;
   logic [IDX_W-1:0]                   idx_ff;
   logic [IDX_W-1:0]                   count_eff;

   // harmonic pipeline
   logic                               v1_ff;
   logic                               v2_ff;
   logic [sfs_pkg::SINE_W-1:0]         sine_ff;
   logic                               neg_ff;
   logic [sfs_pkg::RECIP_W-1:0]        recip_ff;
   logic signed [sfs_pkg::HPROD_W-1:0] hprod_ff;
   logic signed [SUM_W-1:0]            sum_ff;
   logic [SINE_ADDR_BITS+1:0]          abits;
   logic [QA_W-1:0]                    qaddr;
   logic signed [sfs_pkg::SINE_W:0]    sine_s;

   // shared multiplier and wide accumulator
   logic signed [sfs_pkg::MUL_A_W-1:0] mul_a;
   logic signed [sfs_pkg::MUL_B_W-1:0] mul_b;
   logic signed [PP_W-1:0]             pp_ff;
   logic signed [WIDE_W-1:0]           pp_ext;
   logic signed [WIDE_W-1:0]           wide_ff;
   logic signed [WIDE_W-1:0]           rnd;
   logic signed [SUM_W-1:0]            sp;
   logic signed [V_W-1:0]              v_ff;
   logic signed [Y_W-1:0]              y_full;
   logic signed [sfs_pkg::WAVE_W-1:0]  y_sat;

   localparam logic signed [Y_W-1:0] Y_MAX = Y_W'(sfs_pkg::OUT_MAX);
   localparam logic signed [Y_W-1:0] Y_MIN = Y_W'(sfs_pkg::OUT_MIN);
   localparam logic signed [V_W-1:0] V_ONE = V_W'(64'sd1 <<< 30);

   // harmonic count clamped to the table depth
   always_comb begin
      if (32'(cfg.harmonic_count) > 32'(MAX_HARMONICS)) count_eff = IDX_W'(MAX_HARMONICS);
      else count_eff = IDX_W'(cfg.harmonic_count);
   end

   assign status.no_harm   = (count_eff == '0);
   assign status.last_harm = (idx_ff == count_eff);
   assign status.pipe_busy = v1_ff || v2_ff;

   // quarter-wave address folding
   assign abits = angle_ff[sfs_pkg::ANGLE_W-1 -: SINE_ADDR_BITS+2];
   always_comb begin
      if (abits[SINE_ADDR_BITS]) begin
         qaddr = QA_W'(QSIZE) - {1'b0, abits[SINE_ADDR_BITS-1:0]};
      end else begin
         qaddr = {1'b0, abits[SINE_ADDR_BITS-1:0]};
      end
   end

   // angle step and harmonic index
   always_ff @(posedge clock) begin
      case (cmd.op)
         sfs_pkg::OP_INIT: begin
            fp_ff    <= pp_ff[sfs_pkg::ANGLE_W-1:0];
            angle_ff <= pp_ff[sfs_pkg::ANGLE_W-1:0];
            idx_ff   <= IDX_W'(1);
         end
         sfs_pkg::OP_STEP: begin
            angle_ff <= angle_ff + fp_ff;
            idx_ff   <= idx_ff + IDX_W'(1);
         end
         default: begin
         end
      endcase
   end

   // table reads, registered
   always_ff @(posedge clock) begin
      sine_ff  <= QTAB[qaddr];
      neg_ff   <= abits[SINE_ADDR_BITS+1];
      recip_ff <= RTAB[idx_ff];
   end

   assign sine_s = neg_ff ? -$signed({1'b0, sine_ff}) : $signed({1'b0, sine_ff});

   // sine times reciprocal, then accumulate
   always_ff @(posedge clock) begin
      hprod_ff <= sfs_pkg::HPROD_W'(sine_s * $signed({1'b0, recip_ff}));
      if (cmd.op == sfs_pkg::OP_FP) begin
         sum_ff <= '0;
      end else if (v2_ff) begin
         sum_ff <= sum_ff + SUM_W'(hprod_ff);
      end
   end

   // pipeline valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= (cmd.op == sfs_pkg::OP_STEP);
         v2_ff <= v1_ff;
      end
   end

   // shared multiplier operands
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.op)
         sfs_pkg::OP_FP: begin
            mul_a = $signed({9'd0, cfg.frequency});
            mul_b = $signed({15'd0, req_phase});
         end
         sfs_pkg::OP_S_LO: begin
            mul_a = $signed({1'b0, sum_ff[SP_LO-1:0]});
            mul_b = $signed({1'b0, sfs_pkg::INV_PI_Q30});
         end
         sfs_pkg::OP_S_HI: begin
            mul_a = sfs_pkg::MUL_A_W'($signed(sum_ff[SUM_W-1:SP_LO]));
            mul_b = $signed({1'b0, sfs_pkg::INV_PI_Q30});
         end
         sfs_pkg::OP_V_LO: begin
            mul_a = $signed({1'b0, v_ff[SP_LO-1:0]});
            mul_b = sfs_pkg::MUL_B_W'(cfg.amplitude);
         end
         sfs_pkg::OP_V_HI: begin
            mul_a = sfs_pkg::MUL_A_W'($signed(v_ff[V_W-1:SP_LO]));
            mul_b = sfs_pkg::MUL_B_W'(cfg.amplitude);
         end
         default: begin
         end
      endcase
   end

   assign pp_ext = WIDE_W'(pp_ff);
   assign rnd    = wide_ff + (WIDE_W'(1) <<< ((cmd.op == sfs_pkg::OP_OUT) ? 30 : 29));
   assign sp     = rnd[SUM_W+29:30];
   assign y_full = rnd[WIDE_W-1:31];

   // saturate to the output range
   always_comb begin
      if (y_full > Y_MAX) y_sat = sfs_pkg::WAVE_W'(Y_MAX);
      else if (y_full < Y_MIN) y_sat = sfs_pkg::WAVE_W'(Y_MIN);
      else y_sat = y_full[sfs_pkg::WAVE_W-1:0];
   end

   // partial products, split combine, rounding
   always_ff @(posedge clock) begin
      case (cmd.op)
         sfs_pkg::OP_FP,
         sfs_pkg::OP_S_LO,
         sfs_pkg::OP_V_LO: begin
            pp_ff <= mul_a * mul_b;
         end
         sfs_pkg::OP_S_HI,
         sfs_pkg::OP_V_HI: begin
            pp_ff   <= mul_a * mul_b;
            wide_ff <= pp_ext;
         end
         sfs_pkg::OP_S_ADD,
         sfs_pkg::OP_V_ADD: begin
            wide_ff <= wide_ff + (pp_ext <<< SP_LO);
         end
         sfs_pkg::OP_ROUND: begin
            v_ff <= V_ONE - V_W'(sp);
         end
         default: begin
         end
      endcase
   end

   // result register and strobe
   always_ff @(posedge clock) begin
      if (cmd.op == sfs_pkg::OP_OUT) begin
         rsp_wave_value <= y_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe <= 1'b0;
      end else begin
         rsp_strobe <= (cmd.op == sfs_pkg::OP_OUT);
      end
   end

endmodule

>>> verif/tb_sawtooth_fourier_series_synth_top.sv
`timescale 1ns / 1ps

module tb_sawtooth_fourier_series_synth_top;

   localparam int MAX_HARM   = 64;
   localparam int ADDR_BITS  = 10;
   localparam int QUARTER_N  = 1 << ADDR_BITS;
   localparam int CYCLE_CAP  = 1000000;
   localparam int SWEEP_SETS = 31;
   localparam int SWEEP_LEN  = 50;
   localparam logic [sfs_pkg::CSR_INDEX_W-1:0] CSR_UNMAPPED = 2'd3;

   logic                                  clock = 1'b0;
   logic                                  reset = 1'b1;
   logic                                  start = 1'b0;
   logic                                  busy;
   logic [sfs_pkg::PHASE_W-1:0]           req_phase = '0;
   logic                                  rsp_strobe;
   logic signed [sfs_pkg::WAVE_W-1:0]     rsp_wave_value;
   logic                                  csr_valid = 1'b0;
   logic                                  csr_ready;
   logic [sfs_pkg::CSR_INDEX_W-1:0]       csr_index = '0;
   logic [sfs_pkg::CSR_DATA_W-1:0]        csr_data = '0;

   // shadow copy of the block registers
   logic [6:0]                    cfg_harmonics = sfs_pkg::HARMONIC_COUNT_RST;
   logic signed [15:0]            cfg_amplitude = sfs_pkg::AMPLITUDE_RST;
   logic [15:0]                   cfg_frequency = sfs_pkg::FREQUENCY_RST;

   // constant sine and reciprocal roms
   int                            quarter_sine_rom [0:QUARTER_N];
   longint                        recip_rom [0:MAX_HARM];

   logic signed [sfs_pkg::WAVE_W-1:0] wave_expected [$];
   int                            mismatch_count = 0;
   int                            samples_sent = 0;
   int                            samples_checked = 0;
   int                            csr_writes = 0;
   int                            settings_used = 0;
   int                            cycle_count = 0;
   bit                            quiet_run = 1'b0;

   sawtooth_fourier_series_synth_top #(
      .MAX_HARMONICS (MAX_HARM),
      .SINE_ADDR_BITS(ADDR_BITS)
   ) uut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_phase     (req_phase),
      .rsp_strobe    (rsp_strobe),
      .rsp_wave_value(rsp_wave_value),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   // clock
   initial begin
      forever #6 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_CAP) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, wave_expected.size());
         $display("tb_sawtooth_fourier_series_synth_top: errors");
         $finish;
      end
   end

   // taylor series sine for one quarter-wave entry, q1.15
   function automatic int quarter_entry(int unsigned k);
      longint unsigned x;
      longint unsigned term;
      longint unsigned div;
      longint          acc;
      longint          r;
      x = (sfs_pkg::HALF_PI_Q30 * 64'(k)) >> ADDR_BITS;
      term = x;
      acc = $signed(x);
      for (int unsigned n = 1; n <= 7; n++) begin
         term = (term * x) >> 30;
         term = (term * x) >> 30;
         div = 64'((2 * n) * (2 * n + 1));
         term = term / div;
         if (n % 2 == 1) acc = acc - $signed(term);
         else acc = acc + $signed(term);
      end
      if (acc < 0) acc = 0;
      r = (acc + (longint'(1) <<< 14)) >>> 15;
      if (r > 32768) r = 32768;
      return int'(r);
   endfunction

   function automatic void build_roms();
      for (int k = 0; k <= QUARTER_N; k++) quarter_sine_rom[k] = quarter_entry(k);
      recip_rom[0] = 0;
      for (int i = 1; i <= MAX_HARM; i++) recip_rom[i] = (65536 + i / 2) / i;
   endfunction

   // band-limited sawtooth value for one phase under the shadow registers
   function automatic logic signed [sfs_pkg::WAVE_W-1:0] sawtooth_sample(
      logic [sfs_pkg::PHASE_W-1:0] phase);
      longint unsigned fp;
      longint unsigned t;
      int unsigned     count;
      int unsigned     a;
      int unsigned     quad;
      int unsigned     k;
      int              s;
      longint          acc;
      longint          sp;
      longint          v;
      longint          y;
      fp = 64'(cfg_frequency) * 64'(phase);
      count = (cfg_harmonics > MAX_HARM) ? MAX_HARM : cfg_harmonics;
      acc = 0;
      for (int unsigned i = 1; i <= count; i++) begin
         t = (64'(i) * fp) & 64'hFF_FFFF;
         a = 32'(t >> (22 - ADDR_BITS));
         quad = (a >> ADDR_BITS) & 3;
         k = a & (QUARTER_N - 1);
         s = (quad & 1) ? quarter_sine_rom[QUARTER_N - k] : quarter_sine_rom[k];
         if (quad & 2) s = -s;
         acc = acc + longint'(s) * recip_rom[i];
      end
      sp = (acc * longint'(sfs_pkg::INV_PI_Q30) + (longint'(1) <<< 29)) >>> 30;
      v = (longint'(1) <<< 30) - sp;
      y = (longint'(cfg_amplitude) * v + (longint'(1) <<< 30)) >>> 31;
      if (y > sfs_pkg::OUT_MAX) y = sfs_pkg::OUT_MAX;
      if (y < sfs_pkg::OUT_MIN) y = sfs_pkg::OUT_MIN;
      return y[sfs_pkg::WAVE_W-1:0];
   endfunction

   // result checker
   always @(posedge clock) begin : wave_check
      logic signed [sfs_pkg::WAVE_W-1:0] want;
      if (!reset && rsp_strobe) begin
         if (wave_expected.size() == 0) begin
            mismatch_count = mismatch_count + 1;
            if (mismatch_count <= 10)
               $display("unexpected result %0d with nothing pending", rsp_wave_value);
         end else begin
            want = wave_expected.pop_front();
            samples_checked = samples_checked + 1;
            if (rsp_wave_value !== want) begin
               mismatch_count = mismatch_count + 1;
               if (mismatch_count <= 10)
                  $display("wave_value mismatch: expected %0d, got %0d", want,
                           rsp_wave_value);
            end
         end
      end
   end

   // idle length before the next beat, mostly short
   function automatic int pick_gap();
      int r;
      if (quiet_run) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // one phase beat, held until taken
   task automatic send_phase(logic [sfs_pkg::PHASE_W-1:0] phase, int gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_phase <= phase;
      do @(posedge clock); while (busy);
      wave_expected.push_back(sawtooth_sample(phase));
      samples_sent = samples_sent + 1;
   endtask

   // register write beat; caller lowers csr_valid after the batch
   task automatic csr_write(logic [sfs_pkg::CSR_INDEX_W-1:0] idx,
                            logic [sfs_pkg::CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      csr_writes = csr_writes + 1;
      case (idx)
         sfs_pkg::CSR_HARMONIC_COUNT: cfg_harmonics = data[6:0];
         sfs_pkg::CSR_AMPLITUDE:      cfg_amplitude = data;
         sfs_pkg::CSR_FREQUENCY:      cfg_frequency = data;
         default:                     ;
      endcase
   endtask

   // wait until every pending result is back and the block is idle
   task automatic drain_idle();
      start <= 1'b0;
      while (wave_expected.size() != 0 || busy) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic apply_settings(logic [sfs_pkg::CSR_DATA_W-1:0] harm_word,
                                 logic [sfs_pkg::CSR_DATA_W-1:0] amp_word,
                                 logic [sfs_pkg::CSR_DATA_W-1:0] freq_word, bit junk);
      drain_idle();
      csr_write(sfs_pkg::CSR_HARMONIC_COUNT, harm_word);
      if (junk) csr_write(CSR_UNMAPPED, 16'($urandom));
      csr_write(sfs_pkg::CSR_AMPLITUDE, amp_word);
      csr_write(sfs_pkg::CSR_FREQUENCY, freq_word);
      csr_valid <= 1'b0;
      settings_used = settings_used + 1;
   endtask

   // reset values with phase extremes and quadrant edges
   task automatic test_reset_defaults();
      send_phase(16'h0000, 0);
      send_phase(16'hFFFF, pick_gap());
      send_phase(16'h4000, pick_gap());
      send_phase(16'h8000, 0);
      send_phase(16'hC000, pick_gap());
      send_phase(16'h0001, 0);
      settings_used = settings_used + 1;
   endtask

   // zero harmonics leaves half the amplitude
   task automatic test_no_harmonics();
      apply_settings(16'h0000, 16'h0100, 16'h0100, 1'b0);
      send_phase(16'h0000, 0);
      send_phase(16'h2AAA, 0);
      send_phase(16'hFFFF, pick_gap());
   endtask

   // counts above the maximum clamp to the maximum
   task automatic test_harmonic_clamp();
      apply_settings(16'd64, 16'h0100, 16'h0100, 1'b0);
      send_phase(16'h1000, 0);
      send_phase(16'hF000, 0);
      apply_settings(16'd100, 16'h7FFF, 16'h0100, 1'b0);
      send_phase(16'h1000, 0);
      send_phase(16'h0555, 0);
      apply_settings(16'd127, 16'h8000, 16'hFFFF, 1'b0);
      send_phase(16'h1000, 0);
      send_phase(16'hAAAA, pick_gap());
   endtask

   // register extremes, upper bits beyond the count and the unmapped index
   task automatic test_register_extremes();
      apply_settings(16'hFF81, 16'h8000, 16'h0000, 1'b1);
      send_phase(16'h3333, 0);
      send_phase(16'hFFFF, 0);
      apply_settings(16'hAB0C, 16'h7FFF, 16'hFFFF, 1'b1);
      send_phase(16'h5555, 0);
      send_phase(16'h0001, pick_gap());
      apply_settings(16'h0008, 16'h0000, 16'h8001, 1'b0);
      send_phase(16'h7FFF, 0);
   endtask

   // random settings, each followed by a run of random phases
   task automatic test_random_sweep();
      logic [6:0]                   harm;
      logic [15:0]                  amp;
      logic [15:0]                  freq;
      logic [sfs_pkg::PHASE_W-1:0]  phase;
      for (int set = 0; set < SWEEP_SETS; set++) begin
         case ($urandom_range(0, 9))
            0:       harm = 7'd0;
            1:       harm = 7'd1;
            2:       harm = 7'd64;
            3:       harm = 7'($urandom_range(65, 127));
            default: harm = 7'($urandom_range(1, 24));
         endcase
         case ($urandom_range(0, 7))
            0:       amp = 16'h8000;
            1:       amp = 16'h7FFF;
            2:       amp = 16'h0000;
            3:       amp = 16'h0100;
            default: amp = 16'($urandom);
         endcase
         case ($urandom_range(0, 7))
            0:       freq = 16'h0000;
            1:       freq = 16'hFFFF;
            2:       freq = 16'h0100;
            default: freq = 16'($urandom);
         endcase
         apply_settings({9'($urandom), harm}, amp, freq, $urandom_range(0, 3) == 0);
         quiet_run = ($urandom_range(0, 3) == 0);
         for (int n = 0; n < SWEEP_LEN; n++) begin
            case ($urandom_range(0, 19))
               0:       phase = 16'h0000;
               1:       phase = 16'hFFFF;
               default: phase = 16'($urandom);
            endcase
            send_phase(phase, pick_gap());
         end
         quiet_run = 1'b0;
      end
   endtask

   // main sequence
   initial begin
      build_roms();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_no_harmonics();
      test_harmonic_clamp();
      test_register_extremes();
      test_random_sweep();
      drain_idle();
      repeat (20) @(posedge clock);
      $display("sent %0d phase samples, checked %0d results, %0d mismatches",
               samples_sent, samples_checked, mismatch_count);
      $display("used %0d register settings through %0d register writes",
               settings_used, csr_writes);
      if (mismatch_count == 0 && wave_expected.size() == 0) begin
         $display("tb_sawtooth_fourier_series_synth_top: clean");
      end else begin
         $display("tb_sawtooth_fourier_series_synth_top: errors");
      end
      $finish;
   end

endmodule

>>> filelist.f
design/sfs_pkg.sv
design/sfs_csr.sv
design/sfs_ctrl.sv
design/sfs_dpath.sv
design/sawtooth_fourier_series_synth_top.sv
verif/tb_sawtooth_fourier_series_synth_top.sv
